### design/btel_pkg.sv
// Shared types, sizes and event codes of the trigger-box event block.
`default_nettype none
package btel_pkg;

   localparam int MAX_BOXES   = 32;
   localparam int MAX_INSIDE  = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam int BOX_IDX_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int BOX_CNT_W    = $clog2(MAX_BOXES + 1);
   localparam int INSIDE_IDX_W = (MAX_INSIDE > 1) ? $clog2(MAX_INSIDE) : 1;
   localparam int INSIDE_CNT_W = $clog2(MAX_INSIDE + 1);

   localparam int SLOT_W     = 5;
   localparam int COORD_W    = 16;
   localparam int NAME_W     = 16;
   localparam int CORNER_W   = 3 * COORD_W;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 16;
   localparam int CFG_W      = 6;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register index as seen in paddr[2].
   localparam logic CSR_IDX_ACTIVE_BOXES = 1'b0;

   localparam logic KIND_LOAD     = 1'b0;
   localparam logic KIND_POSITION = 1'b1;

   localparam logic [1:0] EV_ENTERED = 2'd0;
   localparam logic [1:0] EV_STILL   = 2'd1;
   localparam logic [1:0] EV_LEFT    = 2'd2;

   // One classified command from the front to the back. For a position
   // update the point travels in the lo field.
   typedef struct packed {
      logic                is_pos;
      logic [SLOT_W-1:0]   slot;
      logic [CORNER_W-1:0] lo;
      logic [CORNER_W-1:0] hi;
      logic [NAME_W-1:0]   name;
   } cmd_type;

   // One entry of the box table memory.
   typedef struct packed {
      logic [NAME_W-1:0]   name;
      logic [CORNER_W-1:0] hi;
      logic [CORNER_W-1:0] lo;
   } box_type;

   localparam int BOX_W = $bits(box_type);

endpackage
`default_nettype wire

### design/btel_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module btel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

### design/btel_front.sv
// Front part: accepts input transfers, classifies them and holds the register.
`default_nettype none
module btel_front import btel_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [0:0]            req_tuser,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic                       cmd_valid,
   input  wire logic                  cmd_ready,
   output cmd_type                    cmd,
   output logic      [BOX_CNT_W-1:0]  box_count
);
   logic [CFG_W-1:0] active_boxes_ff;
   logic [CFG_W-1:0] active_boxes_in;
   logic             keep;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == CSR_IDX_ACTIVE_BOXES);

   always_comb begin
      active_boxes_in = active_boxes_ff;
      if (csr_write) begin
         active_boxes_in = csr_pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_boxes_ff <= '0;
      end else begin
         active_boxes_ff <= active_boxes_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_ACTIVE_BOXES)
                       ? CSR_DATA_W'(active_boxes_ff) : '0;

   // Counts above the table size scan the whole table.
   always_comb begin
      if (32'(active_boxes_ff) > 32'(MAX_BOXES)) begin
         box_count = BOX_CNT_W'(MAX_BOXES);
      end else begin
         box_count = BOX_CNT_W'(active_boxes_ff);
      end
   end

   always_comb begin
      cmd.is_pos = (req_tuser[0] == KIND_POSITION);
      cmd.slot   = req_tdata[4:0];
      cmd.lo     = cmd.is_pos ? req_tdata[164:117] : req_tdata[52:5];
      cmd.hi     = req_tdata[100:53];
      cmd.name   = req_tdata[116:101];
   end

   // A load aimed beyond the table is taken and dropped.
   assign keep       = cmd.is_pos || (32'(cmd.slot) < 32'(MAX_BOXES));
   assign cmd_valid  = req_tvalid && keep;
   assign req_tready = !keep || cmd_ready;
endmodule
`default_nettype wire

### design/btel_cmd_queue.sv
// Short command queue between the front and the back part.
`default_nettype none
module btel_cmd_queue import btel_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_cmd
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = q_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule
`default_nettype wire

### design/btel_back.sv
// Back part: box table, scan sequencer, inside lists and event output.
`default_nettype none
module btel_back import btel_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   output logic                       cmd_ready,
   input  wire cmd_type               cmd,
   input  wire logic [BOX_CNT_W-1:0]  box_count,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic      [1:0]            rsp_tuser,
   output logic                       rsp_tlast
);
   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LEAVE, ST_FINISH} state_type;

   state_type               state_ff, state_in;
   logic [BOX_CNT_W-1:0]    idx_ff, idx_in;
   logic [BOX_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CORNER_W-1:0]     pos_ff, pos_in;
   logic [NAME_W-1:0]       prior_ff [MAX_INSIDE];
   logic [NAME_W-1:0]       prior_in [MAX_INSIDE];
   logic [INSIDE_CNT_W-1:0] prior_cnt_ff, prior_cnt_in;
   logic [NAME_W-1:0]       fresh_ff [MAX_INSIDE];
   logic [NAME_W-1:0]       fresh_in [MAX_INSIDE];
   logic [INSIDE_CNT_W-1:0] fresh_cnt_ff, fresh_cnt_in;
   logic                    pend_v_ff, pend_v_in;
   logic [1:0]              pend_kind_ff, pend_kind_in;
   logic [NAME_W-1:0]       pend_name_ff, pend_name_in;
   logic                    out_v_ff, out_v_in;
   logic [1:0]              out_kind_ff, out_kind_in;
   logic [NAME_W-1:0]       out_name_ff, out_name_in;
   logic                    out_last_ff, out_last_in;

   logic                    ram_wr_en, ram_rd_en;
   logic [BOX_IDX_W-1:0]    ram_rd_addr;
   logic [BOX_W-1:0]        ram_rd_data;
   box_type                 box;
   box_type                 load_box;

   logic                    hit;
   logic                    found;
   logic [INSIDE_IDX_W-1:0] found_idx;
   logic [INSIDE_IDX_W-1:0] tail_idx;
   logic                    fresh_hit;
   logic                    new_ev;
   logic [1:0]              new_kind;
   logic [NAME_W-1:0]       new_name;
   logic                    out_free;
   logic                    stall;

   assign load_box.name = cmd.name;
   assign load_box.hi   = cmd.hi;
   assign load_box.lo   = cmd.lo;

   btel_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cmd.slot[BOX_IDX_W-1:0]),
      .wr_data (load_box),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign box = box_type'(ram_rd_data);

   always_comb begin
      hit = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if ($signed(pos_ff[COORD_W*a +: COORD_W]) < $signed(box.lo[COORD_W*a +: COORD_W])
             || $signed(pos_ff[COORD_W*a +: COORD_W])
                >= $signed(box.hi[COORD_W*a +: COORD_W])) begin
            hit = 1'b0;
         end
      end
   end

   // First prior entry carrying the box name, and whether the fresh list has it.
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      fresh_hit = 1'b0;
      for (int j = 0; j < MAX_INSIDE; j++) begin
         if (!found && (INSIDE_CNT_W'(j) < prior_cnt_ff) && (prior_ff[j] == box.name)) begin
            found     = 1'b1;
            found_idx = INSIDE_IDX_W'(j);
         end
         if ((INSIDE_CNT_W'(j) < fresh_cnt_ff) && (fresh_ff[j] == box.name)) begin
            fresh_hit = 1'b1;
         end
      end
   end

   assign tail_idx = INSIDE_IDX_W'(prior_cnt_ff - 1'b1);

   always_comb begin
      new_ev   = 1'b0;
      new_kind = EV_LEFT;
      new_name = prior_ff[0];
      if (state_ff == ST_SCAN) begin
         new_ev   = hit;
         new_kind = found ? EV_STILL : EV_ENTERED;
         new_name = box.name;
      end else if (state_ff == ST_LEAVE) begin
         new_ev = (prior_cnt_ff != '0);
      end
   end

   // One event is held back so that the final one can carry tlast.
   assign out_free = !out_v_ff || rsp_tready;
   assign stall    = new_ev && pend_v_ff && !out_free;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      prior_in     = prior_ff;
      prior_cnt_in = prior_cnt_ff;
      fresh_in     = fresh_ff;
      fresh_cnt_in = fresh_cnt_ff;
      pend_v_in    = pend_v_ff;
      pend_kind_in = pend_kind_ff;
      pend_name_in = pend_name_ff;
      out_v_in     = out_v_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_name_in  = out_name_ff;
      out_last_in  = out_last_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      cmd_ready    = 1'b0;

      if (new_ev && !stall) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_kind_in = pend_kind_ff;
            out_name_in = pend_name_ff;
            out_last_in = 1'b0;
         end
         pend_v_in    = 1'b1;
         pend_kind_in = new_kind;
         pend_name_in = new_name;
      end

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               if (!cmd.is_pos) begin
                  ram_wr_en = 1'b1;
               end else begin
                  pos_in       = cmd.lo;
                  cnt_in       = box_count;
                  idx_in       = '0;
                  fresh_cnt_in = '0;
                  if (box_count == '0) begin
                     state_in = ST_LEAVE;
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (hit) begin
                  if (found) begin
                     prior_in[found_idx] = prior_ff[tail_idx];
                     prior_cnt_in        = prior_cnt_ff - 1'b1;
                  end
                  if (!fresh_hit && (fresh_cnt_ff < INSIDE_CNT_W'(MAX_INSIDE))) begin
                     fresh_in[INSIDE_IDX_W'(fresh_cnt_ff)] = box.name;
                     fresh_cnt_in = fresh_cnt_ff + 1'b1;
                  end
               end
               if (idx_ff == cnt_ff - 1'b1) begin
                  state_in = ST_LEAVE;
               end else begin
                  idx_in      = idx_ff + 1'b1;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = BOX_IDX_W'(idx_ff + 1'b1);
               end
            end
         end
         ST_LEAVE: begin
            if (prior_cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else if (!stall) begin
               // Leaves go out from the head; the list shifts down behind them.
               for (int j = 0; j < MAX_INSIDE - 1; j++) begin
                  prior_in[j] = prior_ff[j+1];
               end
               prior_cnt_in = prior_cnt_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_v_in    = 1'b1;
                  out_kind_in = pend_kind_ff;
                  out_name_in = pend_name_ff;
                  out_last_in = 1'b1;
                  pend_v_in   = 1'b0;
               end
               prior_in     = fresh_ff;
               prior_cnt_in = fresh_cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prior_cnt_ff <= '0;
         fresh_cnt_ff <= '0;
         pend_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prior_cnt_ff <= prior_cnt_in;
         fresh_cnt_ff <= fresh_cnt_in;
         pend_v_ff    <= pend_v_in;
         out_v_ff     <= out_v_in;
      end
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      pos_ff       <= pos_in;
      prior_ff     <= prior_in;
      fresh_ff     <= fresh_in;
      pend_kind_ff <= pend_kind_in;
      pend_name_ff <= pend_name_in;
      out_kind_ff  <= out_kind_in;
      out_name_ff  <= out_name_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_name_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
endmodule
`default_nettype wire

### design/box_trigger_enter_leave_events.sv
// Top level of the trigger-box enter/leave event block.
//
//   channel  direction  ports   carries
//   req_     in         stream  box load or position update
//   rsp_     out        stream  one enter, still-inside or leave event
//   csr_     in/out     APB     active_boxes register at byte address 0
//
// A box load is written to the box table as the back part takes it. A position
// update takes the command, scans min(active_boxes, 32) boxes with one box
// table read per cycle unless a stall holds it, sends the leave events, sees
// the prior list empty and then closes the update.
// Reset is synchronous; there is no clearing pass.
// A stalled result holds the back part when a further event is ready, and the
// closing cycle waits until the held-back event can move to the output.
// The front keeps taking transfers while the two-entry queue has room.
`default_nettype none
module box_trigger_enter_leave_events import btel_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // entry_index, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
   // box_max_z, box_name, pos_x, pos_y, pos_z, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  wire logic [0:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // object_name
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // event_kind
   output logic      [1:0]            rsp_tuser,
   output logic                       rsp_tlast,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   cmd_type              front_cmd;
   cmd_type              back_cmd;
   logic                 front_valid, front_ready;
   logic                 back_valid, back_ready;
   logic [BOX_CNT_W-1:0] box_count;

   btel_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready),
      .cmd         (front_cmd),
      .box_count   (box_count)
   );

   btel_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   btel_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .box_count  (box_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
`default_nettype wire

### design/btel_checker.sv
// Port-level checker for the trigger-box event block and its bind.
`default_nettype none
module btel_checker import btel_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]            rsp_tuser,
   input wire logic                  rsp_tlast,
   input wire logic                  csr_psel,
   input wire logic                  csr_penable,
   input wire logic                  csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [CSR_DATA_W-1:0] csr_prdata
);
   // A stalled event keeps its value until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == EV_ENTERED || rsp_tuser == EV_STILL
                      || rsp_tuser == EV_LEFT))
      else $error("undefined event kind");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // The register reads back the low CFG_W bits of what was last written to it.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == CSR_IDX_ACTIVE_BOXES
      |=> csr_paddr[2] != CSR_IDX_ACTIVE_BOXES
          || csr_prdata == CSR_DATA_W'($past(csr_pwdata[CFG_W-1:0])))
      else $error("register read-back mismatch");
endmodule

bind box_trigger_enter_leave_events btel_checker u_btel_checker (.*);
`default_nettype wire

### test/box_trigger_enter_leave_events_test.sv
// Self-checking testbench for the trigger-box enter/leave event block.
`default_nettype none
module box_trigger_enter_leave_events_test;
   import btel_pkg::*;

   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 30;
   localparam logic [CSR_ADDR_W-1:0] ACTIVE_BOXES_ADDR = {CSR_IDX_ACTIVE_BOXES, 2'b00};

   typedef struct packed {
      logic                       kind;
      logic [SLOT_W-1:0]          slot;
      logic [2:0][COORD_W-1:0]    lo;
      logic [2:0][COORD_W-1:0]    hi;
      logic [NAME_W-1:0]          name;
      logic [2:0][COORD_W-1:0]    pos;
   } request_t;

   typedef struct packed {
      logic [1:0]        kind;
      logic [NAME_W-1:0] name;
      logic              last;
   } box_event_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   box_trigger_enter_leave_events DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   request_t   pending_requests[$];
   box_event_t expected_events[$];
   int         failures = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic       req_done = 1'b0;

   // Mirror of the box table, the inside lists and the scan length.
   logic [2:0][COORD_W-1:0] box_lo [MAX_BOXES];
   logic [2:0][COORD_W-1:0] box_hi [MAX_BOXES];
   logic [NAME_W-1:0]       box_label [MAX_BOXES];
   logic [NAME_W-1:0]       inside_prior [MAX_INSIDE];
   logic [NAME_W-1:0]       inside_fresh [MAX_INSIDE];
   int                      inside_prior_cnt = 0;
   int                      inside_fresh_cnt = 0;
   logic [CFG_W-1:0]        active_setting = '0;

   function automatic logic [REQ_DATA_W-1:0] pack_request(request_t it);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[0 +: SLOT_W] = it.slot;
      for (int a = 0; a < 3; a++) begin
         d[SLOT_W + a*COORD_W +: COORD_W]       = it.lo[a];
         d[SLOT_W + (3+a)*COORD_W +: COORD_W]   = it.hi[a];
         d[SLOT_W + 6*COORD_W + NAME_W + a*COORD_W +: COORD_W] = it.pos[a];
      end
      d[SLOT_W + 6*COORD_W +: NAME_W] = it.name;
      return d;
   endfunction

   function automatic request_t load_item(int slot, int lx, int ly, int lz,
                                          int hx, int hy, int hz, int name);
      request_t it;
      it = '0;
      it.kind = KIND_LOAD;
      it.slot = SLOT_W'(slot);
      it.lo   = {COORD_W'(lz), COORD_W'(ly), COORD_W'(lx)};
      it.hi   = {COORD_W'(hz), COORD_W'(hy), COORD_W'(hx)};
      it.name = NAME_W'(name);
      return it;
   endfunction

   function automatic request_t position_item(int x, int y, int z);
      request_t it;
      it = '0;
      it.kind = KIND_POSITION;
      it.pos  = {COORD_W'(z), COORD_W'(y), COORD_W'(x)};
      return it;
   endfunction

   // Mostly small boxes around the origin with names from a short list, so that
   // overlaps, shared names and a full inside list come up often.
   function automatic request_t random_load(int slot);
      request_t it;
      int lo_c;
      it = load_item(slot, 0, 0, 0, 0, 0, 0, 0);
      for (int a = 0; a < 3; a++) begin
         if ($urandom_range(99) < 8) begin
            it.lo[a] = COORD_W'($urandom());
            it.hi[a] = COORD_W'($urandom());
         end else begin
            lo_c = $urandom_range(70) - 40;
            it.lo[a] = COORD_W'(lo_c);
            it.hi[a] = COORD_W'(lo_c + $urandom_range(50));
         end
      end
      it.name = ($urandom_range(99) < 80) ? NAME_W'($urandom_range(9))
                                          : NAME_W'($urandom());
      return it;
   endfunction

   task automatic predict_events(input request_t it);
      box_event_t evs[$];
      box_event_t ev;
      int         count;
      logic       hit;
      logic       found;
      logic       dup;
      if (it.kind == KIND_LOAD) begin
         box_lo[it.slot]    = it.lo;
         box_hi[it.slot]    = it.hi;
         box_label[it.slot] = it.name;
         return;
      end
      count = (active_setting > MAX_BOXES) ? MAX_BOXES : int'(active_setting);
      inside_fresh_cnt = 0;
      for (int i = 0; i < count; i++) begin
         hit = 1'b1;
         for (int a = 0; a < 3; a++)
            if ($signed(it.pos[a]) < $signed(box_lo[i][a]) ||
                $signed(it.pos[a]) >= $signed(box_hi[i][a]))
               hit = 1'b0;
         if (hit) begin
            // A name seen before is taken out of the prior list by moving
            // the last entry into its place.
            found = 1'b0;
            for (int j = 0; j < inside_prior_cnt; j++) begin
               if (!found && inside_prior[j] == box_label[i]) begin
                  inside_prior_cnt--;
                  inside_prior[j] = inside_prior[inside_prior_cnt];
                  found = 1'b1;
               end
            end
            ev.kind = found ? EV_STILL : EV_ENTERED;
            ev.name = box_label[i];
            ev.last = 1'b0;
            evs.push_back(ev);
            dup = 1'b0;
            for (int j = 0; j < inside_fresh_cnt; j++)
               if (inside_fresh[j] == box_label[i])
                  dup = 1'b1;
            if (!dup && inside_fresh_cnt < MAX_INSIDE) begin
               inside_fresh[inside_fresh_cnt] = box_label[i];
               inside_fresh_cnt++;
            end
         end
      end
      for (int j = 0; j < inside_prior_cnt; j++) begin
         ev.kind = EV_LEFT;
         ev.name = inside_prior[j];
         ev.last = 1'b0;
         evs.push_back(ev);
      end
      for (int j = 0; j < inside_fresh_cnt; j++)
         inside_prior[j] = inside_fresh[j];
      inside_prior_cnt = inside_fresh_cnt;
      if (evs.size() > 0)
         evs[evs.size()-1].last = 1'b1;
      foreach (evs[k])
         expected_events.push_back(evs[k]);
   endtask

   // Request side: accept and predict at the rising edge.
   always @(posedge clock) begin
      req_done = !reset && req_tvalid && req_tready;
      if (req_done) begin
         predict_events(pending_requests[0]);
         void'(pending_requests.pop_front());
      end
   end

   // Request side: a held transfer stays put until it is taken.
   always @(negedge clock) begin
      if (!(req_tvalid && !req_done)) begin
         if (!reset && pending_requests.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pack_request(pending_requests[0]);
            req_tuser  <= pending_requests[0].kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);

   // Result side: every event is checked against the oldest prediction.
   always @(posedge clock) begin
      box_event_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected event: expected none, got kind %0d name %h last %b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata !== want.name ||
                rsp_tlast !== want.last) begin
               $display("%0t: event mismatch: expected %0d/%h/%b, got %0d/%h/%b",
                        $time, want.kind, want.name, want.last,
                        rsp_tuser, rsp_tdata, rsp_tlast);
               failures++;
            end
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic drain();
      while (pending_requests.size() != 0 || expected_events.size() != 0)
         @(posedge clock);
      // Loads and silent updates may still be inside the block.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active_boxes(input int value);
      logic [CSR_DATA_W-1:0] readback;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ACTIVE_BOXES_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      active_setting = CFG_W'(value);
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      if (readback !== CSR_DATA_W'(active_setting)) begin
         $display("%0t: register readback mismatch: expected %h, got %h",
                  $time, CSR_DATA_W'(active_setting), readback);
         failures++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
         default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
   endtask

   initial begin
      int phase_cfg[6];
      int walk[3];
      phase_cfg = '{32, 63, 1, 33, 20, 7};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. With no boxes active an update says nothing.
      set_idling(0);
      pending_requests.push_back(position_item(0, 0, 0));
      pending_requests.push_back(load_item(0, -32768, -32768, -32768,
                                           32767, 32767, 32767, 16'hFFFF));
      pending_requests.push_back(load_item(1, 0, 0, 0, 1, 1, 1, 0));
      // Same name as the first box, so the second hit reports entered.
      pending_requests.push_back(load_item(2, -10, -10, -10, 10, 10, 10, 16'hFFFF));
      // Empty box: min equals max.
      pending_requests.push_back(load_item(3, 5, 5, 5, 5, 5, 5, 16'h1234));
      for (int s = 4; s < 9; s++)
         pending_requests.push_back(load_item(s, -100, -100, -100, 100, 100, 100, s - 3));
      drain();
      write_active_boxes(9);
      // Seven distinct names contain the origin, one more than the list holds.
      pending_requests.push_back(position_item(0, 0, 0));
      pending_requests.push_back(position_item(0, 0, 0));
      pending_requests.push_back(position_item(1, 1, 1));
      pending_requests.push_back(position_item(-32768, -32768, -32768));
      pending_requests.push_back(position_item(32767, 32767, 32767));
      pending_requests.push_back(position_item(5, 5, 5));
      pending_requests.push_back(position_item(-100, 99, -10));
      pending_requests.push_back(position_item(0, 0, 0));
      drain();
      write_active_boxes(0);
      pending_requests.push_back(position_item(0, 0, 0));

      // Fill the rest of the table before longer scans are enabled.
      set_idling(3);
      for (int s = 9; s < MAX_BOXES; s++)
         pending_requests.push_back(random_load(s));
      drain();

      walk = '{0, 0, 0};
      foreach (phase_cfg[p]) begin
         write_active_boxes(phase_cfg[p]);
         set_idling(p);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) < 25) begin
               pending_requests.push_back(random_load($urandom_range(MAX_BOXES - 1)));
            end else if ($urandom_range(99) < 10) begin
               pending_requests.push_back(position_item($urandom(), $urandom(), $urandom()));
            end else begin
               // The object wanders through the cluster of boxes.
               for (int a = 0; a < 3; a++) begin
                  walk[a] = walk[a] + $urandom_range(16) - 8;
                  if (walk[a] < -60 || walk[a] > 80)
                     walk[a] = $urandom_range(60) - 40;
               end
               pending_requests.push_back(position_item(walk[0], walk[1], walk[2]));
            end
         end
         drain();
      end

      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
